@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the deframer.
// Each macro takes a label, an antecedent and a consequent, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ src/wsd_pkg.sv @@
// Package of the WebSocket frame deframer: parse phases, opcodes, status codes,
// the queue entry type and small decode functions. No dependencies.
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [15:0] MAX_MSG_RESET = 16'd4096;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;

  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_PING   = 2'd2;
  localparam logic [1:0] KIND_PONG   = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_OPCODE = 2'd1;
  localparam logic [1:0] ST_LEN_LARGE  = 2'd2;
  localparam logic [1:0] ST_MSG_LONG   = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } wsd_phase_t;

  typedef struct packed {
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic        byte_present;
    logic [1:0]  frame_kind;
    logic        last_of_frame;
    logic        message_done;
    logic [15:0] message_bytes;
    logic [1:0]  status;
  } wsd_entry_t;

  function automatic logic [1:0] kind_of(input logic [3:0] op);
    case (op)
      OP_BINARY: kind_of = KIND_BINARY;
      OP_PING:   kind_of = KIND_PING;
      OP_PONG:   kind_of = KIND_PONG;
      default:   kind_of = KIND_TEXT;
    endcase
  endfunction

  function automatic logic opcode_ok(input logic [3:0] op);
    opcode_ok = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
                (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

@@ src/wsd_in_if.sv @@
// Input byte channel of the deframer: valid, ready and one received byte.
// Depends on nothing.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

@@ src/wsd_out_if.sv @@
// Result channel of the deframer: valid, ready and the fields of one result.
// Depends on nothing.
interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_present;
  logic [1:0]  frame_kind;
  logic        last_of_frame;
  logic        message_done;
  logic [15:0] message_bytes;
  logic [1:0]  status;

  modport source (output valid, output payload_byte, output byte_present, output frame_kind,
                  output last_of_frame, output message_done, output message_bytes,
                  output status, input ready);
  modport sink   (input valid, input payload_byte, input byte_present, input frame_kind,
                  input last_of_frame, input message_done, input message_bytes,
                  input status, output ready);
endinterface

@@ src/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer. The byte stream enters on in_ch, one byte per request.
// Each frame header (fin, opcode, mask bit, 7-bit, 16-bit or 64-bit length, mask key)
// is parsed in place; payload bytes leave on out_ch unmasked and tagged with the
// frame kind, last-of-frame, message-done, running message size and status.
// A frame with an empty payload yields one marker result with byte_present low.
// A bad opcode, an over-wide length or an oversized fragmented message yields one
// error result, after which input bytes are still taken but produce nothing
// until reset. cfg_wr_en/cfg_wr_data write max_message_bytes (reset value 4096).
// Throughput is one byte per cycle while out_ch takes results: the header parser
// takes a byte whenever the queue has room, and the queue plus output register
// keep both sides running. A result passes a queue slot, then the output register.
// If out_ch stalls, the two-entry queue fills and in_ch.ready drops until the
// output register is taken again. Reset (rst_n low, synchronous) empties the
// queue and output register and returns the parser to the first header byte.
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  wsd_in_if.sink       in_ch,
  wsd_out_if.source    out_ch,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);
  import wsd_pkg::*;

  logic       q_full, q_push, q_pop, q_not_empty;
  wsd_entry_t q_in, q_head;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_byte     (in_ch.data_byte),
    .in_ready    (in_ch.ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  wsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head_entry (q_head)
  );

  wsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_payload_byte  (out_ch.payload_byte),
    .out_byte_present  (out_ch.byte_present),
    .out_frame_kind    (out_ch.frame_kind),
    .out_last_of_frame (out_ch.last_of_frame),
    .out_message_done  (out_ch.message_done),
    .out_message_bytes (out_ch.message_bytes),
    .out_status        (out_ch.status)
  );

endmodule

@@ src/wsd_front.sv @@
// Front end of the deframer: header parser, length and mask capture, message
// size check and configuration register. Pushes result entries to the queue; uses wsd_pkg.
module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               q_full,
  output logic               q_push,
  output wsd_pkg::wsd_entry_t q_entry
);
  import wsd_pkg::*;

  wsd_phase_t              phase_r, phase_nxt;
  logic [3:0]              opcode_r, opcode_nxt;
  logic                    fin_r, fin_nxt;
  logic                    masked_r, masked_nxt;
  logic [3:0]              lbc_r, lbc_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic [15:0]             total_r, total_nxt;
  logic                    stopped_r, stopped_nxt;
  logic [15:0]             max_r;

  logic                    fire;
  logic                    is_data;
  logic [1:0]              kind;
  logic                    hdr_done;
  logic [LENGTH_BITS-1:0]  len_v;
  logic [LENGTH_BITS-1:0]  rem_shift;
  logic [LENGTH_BITS-1:0]  rem_dec;
  logic [15:0]             room16;
  logic [LENGTH_BITS-1:0]  room;
  logic [15:0]             total_step;
  logic                    last;
  logic                    done;

  assign in_ready  = !q_full;
  assign fire      = in_valid && in_ready;
  assign is_data   = (opcode_r <= OP_BINARY);
  assign kind      = kind_of(opcode_r);
  assign rem_shift = {rem_r[LENGTH_BITS-9:0], in_byte};
  assign rem_dec   = rem_r - LENGTH_BITS'(1);
  assign room16    = max_r - total_r;
  assign room      = LENGTH_BITS'(room16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      opcode_r  <= '0;
      fin_r     <= 1'b0;
      masked_r  <= 1'b0;
      lbc_r     <= '0;
      rem_r     <= '0;
      key_r     <= '0;
      idx_r     <= '0;
      total_r   <= '0;
      stopped_r <= 1'b0;
      max_r     <= MAX_MSG_RESET;
    end else begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      fin_r     <= fin_nxt;
      masked_r  <= masked_nxt;
      lbc_r     <= lbc_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      idx_r     <= idx_nxt;
      total_r   <= total_nxt;
      stopped_r <= stopped_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    opcode_nxt  = opcode_r;
    fin_nxt     = fin_r;
    masked_nxt  = masked_r;
    lbc_nxt     = lbc_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    stopped_nxt = stopped_r;
    q_push      = 1'b0;
    q_entry     = '0;
    hdr_done    = 1'b0;
    len_v       = '0;
    total_step  = total_r;
    last        = 1'b0;
    done        = 1'b0;

    if (fire && !stopped_r) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt    = in_byte[7];
          opcode_nxt = in_byte[3:0];
          masked_nxt = 1'b0;
          rem_nxt    = '0;
          key_nxt    = '0;
          idx_nxt    = '0;
          lbc_nxt    = '0;
          if (!opcode_ok(in_byte[3:0])) begin
            stopped_nxt           = 1'b1;
            phase_nxt             = PH_HDR0;
            q_push                = 1'b1;
            q_entry.frame_kind    = KIND_TEXT;
            q_entry.last_of_frame = 1'b1;
            q_entry.message_bytes = total_r;
            q_entry.status        = ST_BAD_OPCODE;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_nxt = in_byte[7];
          if (in_byte[6:0] <= LEN_SHORT_MAX) begin
            rem_nxt = LENGTH_BITS'(in_byte[6:0]);
            len_v   = LENGTH_BITS'(in_byte[6:0]);
            if (in_byte[7]) begin
              phase_nxt = PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end else begin
            lbc_nxt   = (in_byte[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
            rem_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          if (rem_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
            stopped_nxt           = 1'b1;
            phase_nxt             = PH_HDR0;
            q_push                = 1'b1;
            q_entry.frame_kind    = kind;
            q_entry.last_of_frame = 1'b1;
            q_entry.message_bytes = total_r;
            q_entry.status        = ST_LEN_LARGE;
          end else begin
            rem_nxt = rem_shift;
            lbc_nxt = lbc_r - 4'd1;
            if (lbc_r == 4'd1) begin
              len_v = rem_shift;
              if (masked_r) begin
                phase_nxt = PH_MASK;
              end else begin
                hdr_done = 1'b1;
              end
            end
          end
        end
        PH_MASK: begin
          key_nxt = key_r | (32'(in_byte) << {idx_r, 3'b000});
          if (idx_r == 2'd3) begin
            idx_nxt  = '0;
            len_v    = rem_r;
            hdr_done = 1'b1;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          idx_nxt = idx_r + 2'd1;
          rem_nxt = rem_dec;
          if (is_data && (total_r != 16'hFFFF)) begin
            total_step = total_r + 16'd1;
          end
          last      = (rem_dec == '0);
          done      = is_data && fin_r && last;
          total_nxt = done ? 16'd0 : total_step;
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          q_push                = 1'b1;
          q_entry.raw_byte      = in_byte;
          q_entry.key_byte      = 8'(key_r >> {idx_r, 3'b000});
          q_entry.byte_present  = 1'b1;
          q_entry.frame_kind    = kind;
          q_entry.last_of_frame = last;
          q_entry.message_done  = done;
          q_entry.message_bytes = is_data ? total_step : 16'd0;
          q_entry.status        = ST_OK;
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      if (hdr_done) begin
        if (is_data && (!fin_r || (total_r != 16'd0)) &&
            ((total_r > max_r) || (len_v > room))) begin
          stopped_nxt           = 1'b1;
          phase_nxt             = PH_HDR0;
          q_push                = 1'b1;
          q_entry.frame_kind    = kind;
          q_entry.last_of_frame = 1'b1;
          q_entry.message_bytes = total_r;
          q_entry.status        = ST_MSG_LONG;
        end else if (len_v == '0) begin
          phase_nxt             = PH_HDR0;
          q_push                = 1'b1;
          q_entry.frame_kind    = kind;
          q_entry.last_of_frame = 1'b1;
          q_entry.message_done  = is_data && fin_r;
          q_entry.message_bytes = is_data ? total_r : 16'd0;
          q_entry.status        = ST_OK;
          if (is_data && fin_r) begin
            total_nxt = 16'd0;
          end
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

endmodule

@@ src/wsd_queue.sv @@
// Short queue between the parser front end and the output stage.
// Holds wsd_pkg::wsd_entry_t entries; uses wsd_pkg.
module wsd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsd_pkg::wsd_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output wsd_pkg::wsd_entry_t head_entry
);
  import wsd_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  wsd_entry_t        slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == CntW'(QUEUE_DEPTH));
  assign not_empty  = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CntW'(1);
        2'b01:   count_r <= count_r - CntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ src/wsd_back.sv @@
// Back end of the deframer: unmasks the payload byte of the queue head and
// holds the result in the output register until taken; uses wsd_pkg.
module wsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  wsd_pkg::wsd_entry_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_payload_byte,
  output logic                out_byte_present,
  output logic [1:0]          out_frame_kind,
  output logic                out_last_of_frame,
  output logic                out_message_done,
  output logic [15:0]         out_message_bytes,
  output logic [1:0]          out_status
);
  import wsd_pkg::*;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        present_r;
  logic [1:0]  kind_r;
  logic        last_r;
  logic        done_r;
  logic [15:0] bytes_r;
  logic [1:0]  status_r;

  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r    <= q_head.byte_present ? (q_head.raw_byte ^ q_head.key_byte) : 8'd0;
      present_r <= q_head.byte_present;
      kind_r    <= q_head.frame_kind;
      last_r    <= q_head.last_of_frame;
      done_r    <= q_head.message_done;
      bytes_r   <= q_head.message_bytes;
      status_r  <= q_head.status;
    end
  end

  assign out_valid         = valid_r;
  assign out_payload_byte  = byte_r;
  assign out_byte_present  = present_r;
  assign out_frame_kind    = kind_r;
  assign out_last_of_frame = last_r;
  assign out_message_done  = done_r;
  assign out_message_bytes = bytes_r;
  assign out_status        = status_r;

endmodule

@@ src/wsd_checker.sv @@
// Port-level checks of the deframer result channel, bound to the top level.
// Depends on assert_macros.svh and wsd_pkg.
`include "assert_macros.svh"

module wsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        byte_present,
  input logic        last_of_frame,
  input logic        message_done,
  input logic [1:0]  status
);
  import wsd_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_SAME(a_marker_zero, out_valid && !byte_present, payload_byte == 8'd0)
  `ASSERT_SAME(a_error_shape, out_valid && (status != ST_OK), last_of_frame && !byte_present && !message_done)
  `ASSERT_SAME(a_done_is_last, out_valid && message_done, last_of_frame)

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_byte  (out_ch.payload_byte),
  .byte_present  (out_ch.byte_present),
  .last_of_frame (out_ch.last_of_frame),
  .message_done  (out_ch.message_done),
  .status        (out_ch.status)
);
